@@ rtl/core/casi_pkg.sv @@
package casi_pkg;

  // coordinate width and the widths that follow from it
  localparam int CW     = 16;
  localparam int DEV_W  = CW + 18;
  localparam int STEP_W = CW + 3;
  localparam int SQ_W   = 2 * CW;
  localparam int DIFF_W = CW + 1;
  localparam int SUM_W  = CW + 2;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  typedef enum logic [1:0] {
    QUAD_FIRST,
    QUAD_SECOND,
    QUAD_THIRD,
    QUAD_FOURTH
  } quad_t;

  // 1 when the axis counts up in the given quadrant
  function automatic logic axis_up(input logic axis, input quad_t quad);
    logic up;
    if (axis == AXIS_X) begin
      up = (quad == QUAD_THIRD) || (quad == QUAD_FOURTH);
    end else begin
      up = (quad == QUAD_FIRST) || (quad == QUAD_FOURTH);
    end
    return up;
  endfunction

  // change of x^2+y^2 caused by one step of coordinate c: 2c+1 or -2c+1
  function automatic logic [DEV_W-1:0] step_change(input logic [CW-1:0] c, input logic up);
    logic [DEV_W-1:0] c2;
    logic [DEV_W-1:0] one;
    c2  = {{(DEV_W-CW-1){c[CW-1]}}, c, 1'b0};
    one = {{(DEV_W-1){1'b0}}, 1'b1};
    return up ? (c2 + one) : (one - c2);
  endfunction

endpackage

@@ rtl/core/circular_arc_step_interpolator.sv @@
// a word that is accepted passes through the stage one, stage two and result registers
// before it reaches the outputs
// throughput: one word per cycle when not stalled; stage one squares the four
// coordinates, stage two checks the radii and updates the arc state, then the result
// register holds the word; each stage moves on its own, so bubbles are squeezed out
// under output stall; reset (rst_n low, synchronous): pipeline empty, position,
// deviation, step count, quadrant and axis zero, no move in progress
module circular_arc_step_interpolator (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_command,
  input  logic [casi_pkg::CW-1:0]   in_begin_x,
  input  logic [casi_pkg::CW-1:0]   in_begin_y,
  input  logic [casi_pkg::CW-1:0]   in_finish_x,
  input  logic [casi_pkg::CW-1:0]   in_finish_y,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_step_valid,
  output logic                      out_step_axis,
  output logic                      out_step_up,
  output logic                      out_busy_res,
  output logic                      out_move_done,
  output logic                      out_rejected
);

  // ---------------------------------------------------------------- handshake
  logic out_free, s2_free, s1_free, s2_go, s1_go;

  // stage one: registered input word
  logic                          s1_v_r;
  logic                          s1_cmd_r;
  logic [casi_pkg::CW-1:0]       s1_bx_r, s1_by_r, s1_fx_r, s1_fy_r;

  // stage two: squares, step count and start==end flag
  logic                          s2_v_r;
  logic                          s2_cmd_r;
  logic [casi_pkg::CW-1:0]       s2_bx_r, s2_by_r;
  logic [casi_pkg::SQ_W-1:0]     s2_sqbx_r, s2_sqby_r, s2_sqfx_r, s2_sqfy_r;
  logic                          s2_same_r;
  logic [casi_pkg::STEP_W-1:0]   s2_steps_r;

  // arc state
  logic [casi_pkg::CW-1:0]       pos_x_r, pos_y_r;
  logic [casi_pkg::CW-1:0]       pos_x_nxt, pos_y_nxt;
  logic [casi_pkg::DEV_W-1:0]    dev_r, dev_nxt;
  logic [casi_pkg::STEP_W-1:0]   steps_r, steps_nxt;
  casi_pkg::quad_t               quad_r, quad_nxt;
  logic                          axis_r, axis_nxt;
  logic                          moving_r, moving_nxt;

  // result register
  logic out_valid_r;
  logic step_valid_r, step_axis_r, step_up_r, busy_r, done_r, rej_r;
  logic step_valid_nxt, step_axis_nxt, step_up_nxt, busy_nxt, done_nxt, rej_nxt;

  // each stage can take a new word when empty or when it passes its own on
  assign out_free = !out_valid_r || out_ready;
  assign s2_go    = s2_v_r && out_free;
  assign s2_free  = !s2_v_r || out_free;
  assign s1_go    = s1_v_r && s2_free;
  assign s1_free  = !s1_v_r || s2_free;
  assign in_ready = s1_free;

  // ---------------------------------------------------------------- stage one logic
  logic [casi_pkg::SQ_W-1:0]     bx_ext, by_ext, fx_ext, fy_ext;
  logic [casi_pkg::SQ_W-1:0]     sqbx, sqby, sqfx, sqfy;
  logic [casi_pkg::DIFF_W-1:0]   dx, dy, adx, ady;
  logic [casi_pkg::SUM_W-1:0]    step_sum;

  // sign-extended operands: the low half of the product is the exact square
  assign bx_ext = {{casi_pkg::CW{s1_bx_r[casi_pkg::CW-1]}}, s1_bx_r};
  assign by_ext = {{casi_pkg::CW{s1_by_r[casi_pkg::CW-1]}}, s1_by_r};
  assign fx_ext = {{casi_pkg::CW{s1_fx_r[casi_pkg::CW-1]}}, s1_fx_r};
  assign fy_ext = {{casi_pkg::CW{s1_fy_r[casi_pkg::CW-1]}}, s1_fy_r};
  assign sqbx   = bx_ext * bx_ext;
  assign sqby   = by_ext * by_ext;
  assign sqfx   = fx_ext * fx_ext;
  assign sqfy   = fy_ext * fy_ext;

  // step count |dx|+|dy|
  assign dx  = {s1_fx_r[casi_pkg::CW-1], s1_fx_r} - {s1_bx_r[casi_pkg::CW-1], s1_bx_r};
  assign dy  = {s1_fy_r[casi_pkg::CW-1], s1_fy_r} - {s1_by_r[casi_pkg::CW-1], s1_by_r};
  assign adx = dx[casi_pkg::DIFF_W-1] ? (~dx + 1'b1) : dx;
  assign ady = dy[casi_pkg::DIFF_W-1] ? (~dy + 1'b1) : dy;
  assign step_sum = {1'b0, adx} + {1'b0, ady};

  // ---------------------------------------------------------------- stage two logic
  logic                          is_start, radius_ok, start_ok;
  logic                          bx_zero, by_zero, bx_neg, by_neg;
  casi_pkg::quad_t               start_quad;
  logic                          start_axis;
  logic                          tk_up, tk_outside, tk_q13, tk_next_axis;
  logic [casi_pkg::CW-1:0]       tk_delta, tk_px, tk_py;
  logic [casi_pkg::STEP_W-1:0]   tk_steps;
  casi_pkg::quad_t               chg_quad;
  logic                          chg_axis;
  logic [casi_pkg::CW-1:0]       chg_x, chg_y, chg_c;
  logic [casi_pkg::DEV_W-1:0]    chg_base, dev_sum;

  assign is_start  = (s2_cmd_r == casi_pkg::CMD_START);
  assign radius_ok = (s2_sqbx_r + s2_sqby_r) == (s2_sqfx_r + s2_sqfy_r);
  assign start_ok  = is_start && !moving_r && radius_ok && !s2_same_r;

  assign bx_zero = (s2_bx_r == '0);
  assign by_zero = (s2_by_r == '0);
  assign bx_neg  = s2_bx_r[casi_pkg::CW-1];
  assign by_neg  = s2_by_r[casi_pkg::CW-1];

  // quadrant of the start point; a point on the y axis goes to second or fourth
  always_comb begin
    if (!bx_neg && !bx_zero) begin
      start_quad = by_neg ? casi_pkg::QUAD_FOURTH : casi_pkg::QUAD_FIRST;
    end else if (bx_neg) begin
      start_quad = (!by_neg && !by_zero) ? casi_pkg::QUAD_SECOND : casi_pkg::QUAD_THIRD;
    end else begin
      start_quad = by_neg ? casi_pkg::QUAD_FOURTH : casi_pkg::QUAD_SECOND;
    end
  end

  // a start on the x axis begins with a y step
  assign start_axis = by_zero ? casi_pkg::AXIS_Y : casi_pkg::AXIS_X;

  // tick: move the active axis by one, then pick the next axis
  assign tk_up        = casi_pkg::axis_up(axis_r, quad_r);
  assign tk_delta     = {{(casi_pkg::CW-1){~tk_up}}, 1'b1};
  assign tk_px        = (axis_r == casi_pkg::AXIS_X) ? (pos_x_r + tk_delta) : pos_x_r;
  assign tk_py        = (axis_r == casi_pkg::AXIS_Y) ? (pos_y_r + tk_delta) : pos_y_r;
  assign tk_outside   = !dev_r[casi_pkg::DEV_W-1];
  assign tk_q13       = (quad_r == casi_pkg::QUAD_FIRST) || (quad_r == casi_pkg::QUAD_THIRD);
  assign tk_next_axis = (tk_outside == tk_q13) ? casi_pkg::AXIS_X : casi_pkg::AXIS_Y;
  assign tk_steps     = steps_r - 1'b1;

  // one deviation adder shared by start and tick
  always_comb begin
    if (start_ok) begin
      chg_quad = start_quad;
      chg_axis = start_axis;
      chg_x    = s2_bx_r;
      chg_y    = s2_by_r;
      chg_base = '0;
    end else begin
      chg_quad = quad_r;
      chg_axis = tk_next_axis;
      chg_x    = tk_px;
      chg_y    = tk_py;
      chg_base = dev_r;
    end
  end

  assign chg_c   = (chg_axis == casi_pkg::AXIS_X) ? chg_x : chg_y;
  assign dev_sum = chg_base + casi_pkg::step_change(chg_c, casi_pkg::axis_up(chg_axis, chg_quad));

  // next state and result word
  always_comb begin
    pos_x_nxt      = pos_x_r;
    pos_y_nxt      = pos_y_r;
    dev_nxt        = dev_r;
    steps_nxt      = steps_r;
    quad_nxt       = quad_r;
    axis_nxt       = axis_r;
    moving_nxt     = moving_r;
    step_valid_nxt = 1'b0;
    step_axis_nxt  = 1'b0;
    step_up_nxt    = 1'b0;
    busy_nxt       = 1'b0;
    done_nxt       = 1'b0;
    rej_nxt        = 1'b0;
    if (is_start) begin
      busy_nxt = moving_r || start_ok;
      rej_nxt  = !start_ok;
      if (start_ok) begin
        pos_x_nxt  = s2_bx_r;
        pos_y_nxt  = s2_by_r;
        dev_nxt    = dev_sum;
        steps_nxt  = s2_steps_r;
        quad_nxt   = start_quad;
        axis_nxt   = start_axis;
        moving_nxt = 1'b1;
      end
    end else if (moving_r) begin
      pos_x_nxt      = tk_px;
      pos_y_nxt      = tk_py;
      dev_nxt        = dev_sum;
      steps_nxt      = tk_steps;
      axis_nxt       = tk_next_axis;
      moving_nxt     = (tk_steps != '0);
      step_valid_nxt = 1'b1;
      step_axis_nxt  = axis_r;
      step_up_nxt    = tk_up;
      busy_nxt       = (tk_steps != '0);
      done_nxt       = (tk_steps == '0);
    end
  end

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      dev_r       <= '0;
      steps_r     <= '0;
      quad_r      <= casi_pkg::QUAD_FIRST;
      axis_r      <= casi_pkg::AXIS_X;
      moving_r    <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_v_r <= in_valid;
      end
      if (s2_free) begin
        s2_v_r <= s1_v_r;
      end
      if (out_free) begin
        out_valid_r <= s2_v_r;
      end
      // arc state moves only when a word leaves stage two
      if (s2_go) begin
        pos_x_r  <= pos_x_nxt;
        pos_y_r  <= pos_y_nxt;
        dev_r    <= dev_nxt;
        steps_r  <= steps_nxt;
        quad_r   <= quad_nxt;
        axis_r   <= axis_nxt;
        moving_r <= moving_nxt;
      end
    end
  end

  // ---------------------------------------------------------------- payload registers
  always_ff @(posedge clk) begin
    if (s1_free && in_valid) begin
      s1_cmd_r <= in_command;
      s1_bx_r  <= in_begin_x;
      s1_by_r  <= in_begin_y;
      s1_fx_r  <= in_finish_x;
      s1_fy_r  <= in_finish_y;
    end
    if (s1_go) begin
      s2_cmd_r   <= s1_cmd_r;
      s2_bx_r    <= s1_bx_r;
      s2_by_r    <= s1_by_r;
      s2_sqbx_r  <= sqbx;
      s2_sqby_r  <= sqby;
      s2_sqfx_r  <= sqfx;
      s2_sqfy_r  <= sqfy;
      s2_same_r  <= (s1_bx_r == s1_fx_r) && (s1_by_r == s1_fy_r);
      s2_steps_r <= {{(casi_pkg::STEP_W-casi_pkg::SUM_W){1'b0}}, step_sum};
    end
    if (s2_go) begin
      step_valid_r <= step_valid_nxt;
      step_axis_r  <= step_axis_nxt;
      step_up_r    <= step_up_nxt;
      busy_r       <= busy_nxt;
      done_r       <= done_nxt;
      rej_r        <= rej_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_step_valid = step_valid_r;
  assign out_step_axis  = step_axis_r;
  assign out_step_up    = step_up_r;
  assign out_busy_res   = busy_r;
  assign out_move_done  = done_r;
  assign out_rejected   = rej_r;

endmodule
